// ----- design/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg - shared types and constants of the substring replace unit
// Job descriptor passed from the classifying front to the emitting back,
// register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ssr_pkg;

	// Upper bound of both length parameters; fixes the job payload width
	localparam int MAX_LEN_BOUND   = 8;
	localparam int DEF_MAX_PAT_LEN = 8;
	localparam int DEF_MAX_REP_LEN = 8;
	localparam int QUEUE_DEPTH     = 4;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = MAX_LEN_BOUND * BYTE_W;   // 64, pattern and replacement
	localparam int LEN_W   = 4;                        // length registers and job count
	localparam int IDX_W   = 3;                        // beat index inside a job
	localparam int WCNT_W  = 3;                        // bytes held in the window
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES     = 2'd0,
		REG_PATTERN_LEN       = 2'd1,
		REG_REPLACEMENT_BYTES = 2'd2,
		REG_REPLACEMENT_LEN   = 2'd3
	} cfg_reg_t;

	// One job = the result beats caused by one input item.
	// count 0 with eot set is a bare end marker.
	typedef struct packed {
		logic [WORD_W-1:0] data;    // beat n in bits 8n+7..8n
		logic [LEN_W-1:0]  count;
		logic              eot;
	} job_t;

endpackage

// ----- design/streaming_substring_replace_unit.sv -----
// ----------------------------------------------------------------------------
// streaming_substring_replace_unit - find and replace all on a byte stream
// Path: jobs are registered in the job queue, result beats in the output register.
// Throughput: one byte per cycle while the job queue has room; an item causing n result
// beats holds the back end for n beats; the four-entry job queue lets the input run on.
// Reset: pattern 0, pattern length 1, empty replacement, empty window, queue empty.
// ----------------------------------------------------------------------------
//
// Structure:
//   ssr_front  - configuration registers, window of held bytes, compare against
//                the pattern in the cycle the byte arrives, build at most one job per
//                item (replacement, oldest byte, window flush or end marker).
//   ssr_queue  - four jobs deep; input stalls only when it fills up.
//   ssr_back   - output register, head-job result beats, one per cycle unless stalled.
//
// Items that produce nothing (byte just held in the window) push no job, so a
// stream with no matches moves at one beat per cycle in and out unless output stalls.
// The user must write configuration only while idle (not enforced by the unit); a
// pattern length write drops any bytes held in the window.
module streaming_substring_replace_unit import ssr_pkg::*; #(
	parameter int MAX_PATTERN_LEN     = DEF_MAX_PAT_LEN,
	parameter int MAX_REPLACEMENT_LEN = DEF_MAX_REP_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// text in
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 end_of_text,
	// rewritten text out
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 byte_valid,
	output logic                 last_of_run,
	output logic                 text_end
);

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;

	ssr_front #(
		.MAX_PATTERN_LEN     (MAX_PATTERN_LEN),
		.MAX_REPLACEMENT_LEN (MAX_REPLACEMENT_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.queue_full  (q_full),
		.push        (push),
		.job         (push_job)
	);

	ssr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	ssr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.head_valid  (!q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.text_end    (text_end)
	);

endmodule

// ----- design/ssr_front.sv -----
// ----------------------------------------------------------------------------
// ssr_front - window, compare and job builder
// Holds the configuration registers and the unmatched-byte window, takes one
// text byte per cycle while the queue has room, turns it into at most one job.
// ----------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; #(
	parameter int MAX_PATTERN_LEN     = DEF_MAX_PAT_LEN,
	parameter int MAX_REPLACEMENT_LEN = DEF_MAX_REP_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 end_of_text,
	input  logic                 queue_full,
	output logic                 push,
	output job_t                 job
);

	logic [WORD_W-1:0] pattern_q;
	logic [LEN_W-1:0]  pat_len_q;
	logic [WORD_W-1:0] repl_q;
	logic [LEN_W-1:0]  repl_len_q;

	logic [BYTE_W-1:0] win_q [MAX_PATTERN_LEN];
	logic [WCNT_W-1:0] wcnt_q;

	logic [BYTE_W-1:0] win_new   [MAX_PATTERN_LEN];
	logic [BYTE_W-1:0] win_shift [MAX_PATTERN_LEN];
	logic [LEN_W-1:0]  plen_eff;
	logic [LEN_W-1:0]  rlen_eff;
	logic [LEN_W-1:0]  held_inc;
	logic              accept;
	logic              full;
	logic              hit;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		if (pat_len_q == '0) begin
			plen_eff = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(MAX_PATTERN_LEN)) begin
			plen_eff = LEN_W'(MAX_PATTERN_LEN);
		end else begin
			plen_eff = pat_len_q;
		end
		if (repl_len_q > LEN_W'(MAX_REPLACEMENT_LEN)) begin
			rlen_eff = LEN_W'(MAX_REPLACEMENT_LEN);
		end else begin
			rlen_eff = repl_len_q;
		end
	end

	assign held_inc = LEN_W'(wcnt_q) + LEN_W'(1);
	assign full     = (held_inc == plen_eff);

	// new byte dropped in behind the held ones, then compared
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
			win_new[i] = (WCNT_W'(i) == wcnt_q) ? in_byte : win_q[i];
		end
		for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
			win_shift[i] = (i + 1 < MAX_PATTERN_LEN) ? win_new[(i + 1) % MAX_PATTERN_LEN]
			                                         : win_new[i];
			if (LEN_W'(i) < plen_eff && win_new[i] != pattern_q[i*BYTE_W +: BYTE_W]) begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		job.eot   = end_of_text;
		job.data  = '0;
		job.count = '0;
		if (full && hit) begin
			job.data  = repl_q;
			job.count = rlen_eff;
		end else if (full && !end_of_text) begin
			job.data[BYTE_W-1:0] = win_new[0];
			job.count            = LEN_W'(1);
		end else begin
			// miss at end of text emits the whole window; below length, a flush
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				job.data[i*BYTE_W +: BYTE_W] = win_new[i];
			end
			job.count = (full || end_of_text) ? held_inc : '0;
		end
	end

	assign push = accept && (end_of_text || job.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			pat_len_q  <= LEN_W'(1);
			repl_q     <= '0;
			repl_len_q <= '0;
			wcnt_q     <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATTERN_BYTES:     pattern_q  <= cfg_data;
					REG_PATTERN_LEN:       pat_len_q  <= cfg_data[LEN_W-1:0];
					REG_REPLACEMENT_BYTES: repl_q     <= cfg_data;
					REG_REPLACEMENT_LEN:   repl_len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cfg_write && cfg_reg_t'(cfg_index) == REG_PATTERN_LEN) begin
				wcnt_q <= '0;
			end else if (accept) begin
				if (end_of_text || (full && hit)) begin
					wcnt_q <= '0;
				end else if (!full) begin
					wcnt_q <= WCNT_W'(held_inc);
				end
			end
		end
	end

	// window bytes carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				win_q[i] <= full ? win_shift[i] : win_new[i];
			end
		end
	end

	a_wcnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(wcnt_q) < plen_eff)
		else $error("window holds a full pattern between items");

	a_push_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("job pushed without an accepted byte");

	a_job_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.count <= LEN_W'(MAX_LEN_BOUND)))
		else $error("job longer than eight beats");

endmodule

// ----- design/ssr_queue.sv -----
// ----------------------------------------------------------------------------
// ssr_queue - job queue between front and back
// Small register FIFO, head visible combinationally, same-cycle push and pop.
// ----------------------------------------------------------------------------
module ssr_queue import ssr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full job queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty job queue");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("queue fill count lost a push");

endmodule

// ----- design/ssr_back.sv -----
// ----------------------------------------------------------------------------
// ssr_back - beat emitter
// Walks the head job one byte per unstalled cycle into the output register and
// pops it after its last beat; a bare end marker is a single empty beat.
// ----------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              last_of_run,
	output logic              text_end
);

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              bvalid_q;
	logic              last_q;
	logic              end_q;

	logic              load;
	logic              fire;
	logic              bare;
	logic              last;
	logic [BYTE_W-1:0] sel_byte;

	assign load     = !out_valid_q || !out_stall;
	assign fire     = load && head_valid;
	assign bare     = (head.count == '0);
	assign last     = bare || ((LEN_W'(idx_q) + LEN_W'(1)) == head.count);
	assign sel_byte = BYTE_W'(head.data >> {idx_q, 3'b000});
	assign pop      = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + IDX_W'(1);
			end else if (load) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q   <= bare ? '0 : sel_byte;
			bvalid_q <= !bare;
			last_q   <= last;
			end_q    <= last && head.eot;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign last_of_run = last_q;
	assign text_end    = end_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_end) |-> last_of_run)
		else $error("text end on a beat that is not last of its run");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (last_of_run && text_end && out_byte == '0))
		else $error("empty beat that is not a bare end marker");

	a_idx_resets_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == '0))
		else $error("beat index not cleared after a job");

endmodule

// ----- sim/tb_streaming_substring_replace_unit.sv -----
// ----------------------------------------------------------------------------
// tb_streaming_substring_replace_unit - self-checking bench for find and replace
// Drives byte texts through the unit under several pattern and replacement
// settings, predicts every output beat in a scoreboard and compares field by
// field. Sender and receiver idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_streaming_substring_replace_unit;
	import ssr_pkg::*;

	localparam int          SETTLE_CYCLES  = 6;     // quiet edges after the last beat
	localparam int          HOLD_CYCLES    = 120;   // long receiver hold-off
	localparam int          WATCHDOG_LIMIT = 3000;  // edges with no beat moving
	localparam int          PHASE_ITEMS    = 57;
	localparam int          NUM_PHASES     = 8;
	localparam logic [3:0]  ALL_REGS       = 4'b1111;
	localparam logic [7:0]  CHAR_A         = 8'h61;

	// one beat of rewritten text as seen on the output channel
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              bv;
		logic              run_last;
		logic              text_last;
	} text_beat_t;

	// Scoreboard: keeps its own copy of the registers and the window of held
	// bytes, turns each accepted input beat into the beats it must cause, and
	// checks output beats against the oldest of them.
	class rewrite_scoreboard;
		logic [WORD_W-1:0] pat_word;
		logic [LEN_W-1:0]  pat_len;
		logic [WORD_W-1:0] rep_word;
		logic [LEN_W-1:0]  rep_len;
		logic [BYTE_W-1:0] held[DEF_MAX_PAT_LEN];
		int                held_cnt;
		text_beat_t        rewritten_beats[$];
		int                mismatches;

		function new();
			pat_word   = '0;
			pat_len    = LEN_W'(1);
			rep_word   = '0;
			rep_len    = '0;
			held_cnt   = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [WORD_W-1:0] val);
			case (idx)
				REG_PATTERN_BYTES: pat_word = val;
				REG_PATTERN_LEN: begin
					pat_len  = val[LEN_W-1:0];
					held_cnt = 0;
				end
				REG_REPLACEMENT_BYTES: rep_word = val;
				REG_REPLACEMENT_LEN: rep_len = val[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int match_len();
			if (pat_len == 0)
				return 1;
			if (pat_len > DEF_MAX_PAT_LEN)
				return DEF_MAX_PAT_LEN;
			return pat_len;
		endfunction

		function void note_text_byte(logic [BYTE_W-1:0] b, logic eot);
			int         plen;
			int         rlen;
			int         i;
			bit         hit;
			text_beat_t run[$];
			plen = match_len();
			rlen = (rep_len > DEF_MAX_REP_LEN) ? DEF_MAX_REP_LEN : rep_len;
			if (held_cnt >= plen)
				held_cnt = 0;
			held[held_cnt] = b;
			held_cnt++;
			if (held_cnt == plen) begin
				hit = 1'b1;
				for (i = 0; i < plen; i++)
					if (held[i] != pat_word[BYTE_W*i +: BYTE_W])
						hit = 1'b0;
				if (hit) begin
					for (i = 0; i < rlen; i++)
						run.push_back('{rep_word[BYTE_W*i +: BYTE_W], 1'b1, 1'b0, 1'b0});
					held_cnt = 0;
				end else begin
					run.push_back('{held[0], 1'b1, 1'b0, 1'b0});
					for (i = 1; i < held_cnt; i++)
						held[i-1] = held[i];
					held_cnt--;
				end
			end
			if (eot) begin
				for (i = 0; i < held_cnt; i++)
					run.push_back('{held[i], 1'b1, 1'b0, 1'b0});
				held_cnt = 0;
				if (run.size() == 0)
					run.push_back('{'0, 1'b0, 1'b0, 1'b0});
			end
			if (run.size() != 0) begin
				run[run.size()-1].run_last  = 1'b1;
				run[run.size()-1].text_last = eot;
			end
			foreach (run[k])
				rewritten_beats.push_back(run[k]);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		task check_beat(text_beat_t got);
			text_beat_t want;
			if (rewritten_beats.size() == 0) begin
				report_mismatch($sformatf("beat with none expected, byte %02h", got.ch));
				return;
			end
			want = rewritten_beats.pop_front();
			if (got.ch !== want.ch)
				report_mismatch($sformatf("out_byte %02h, want %02h", got.ch, want.ch));
			if (got.bv !== want.bv)
				report_mismatch($sformatf("byte_valid %b, want %b", got.bv, want.bv));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("last_of_run %b, want %b",
					got.run_last, want.run_last));
			if (got.text_last !== want.text_last)
				report_mismatch($sformatf("text_end %b, want %b",
					got.text_last, want.text_last));
		endtask

		function int pending();
			return rewritten_beats.size();
		endfunction
	endclass

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_PATTERN_BYTES;
	logic [WORD_W-1:0]    cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic [BYTE_W-1:0]    in_byte     = '0;
	logic                 end_of_text = 1'b0;
	logic                 out_stall   = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [BYTE_W-1:0]    out_byte;
	logic                 byte_valid;
	logic                 last_of_run;
	logic                 text_end;

	rewrite_scoreboard sb;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	bit hold_request  = 1'b0;

	streaming_substring_replace_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.text_end    (text_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// drives land, so the scoreboard sees exactly what the unit accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_text_byte(in_byte, end_of_text);
			if (out_valid && !out_stall)
				sb.check_beat('{out_byte, byte_valid, last_of_run, text_end});
		end
	end

	// Receiver: random stall at the current rate, or a long hold-off when asked
	// for one. The hold-off is counted here so the sender keeps running.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// length register value with junk in the unused upper bits
	function automatic logic [WORD_W-1:0] len_word(int n);
		logic [WORD_W-1:0] w;
		w = {$urandom, $urandom};
		w[LEN_W-1:0] = LEN_W'(n);
		return w;
	endfunction

	// Offer one text beat after a random gap and wait until it is taken.
	// Valid is only lowered when a gap is actually inserted.
	task automatic send_byte(logic [BYTE_W-1:0] b, logic eot);
		int gap;
		gap = 0;
		while (gap < 6 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every predicted beat has come out. Checked
	// at the falling edge so the scoreboard is up to date; then a few more
	// edges since an item that held its byte leaves nothing to wait for.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Program the registers picked by mask, only once the unit has gone idle
	task automatic load_setting(logic [3:0] mask, logic [WORD_W-1:0] pw,
			logic [WORD_W-1:0] pl, logic [WORD_W-1:0] rw, logic [WORD_W-1:0] rl);
		drain();
		if (mask[REG_PATTERN_BYTES])
			write_reg(REG_PATTERN_BYTES, pw);
		if (mask[REG_PATTERN_LEN])
			write_reg(REG_PATTERN_LEN, pl);
		if (mask[REG_REPLACEMENT_BYTES])
			write_reg(REG_REPLACEMENT_BYTES, rw);
		if (mask[REG_REPLACEMENT_LEN])
			write_reg(REG_REPLACEMENT_LEN, rl);
		cfg_write <= 1'b0;
	endtask

	// Random text built mostly from whole and broken copies of the pattern so
	// that matches, near misses and overlaps are frequent; the rest is noise.
	task automatic send_random_text(int items, int pause_at, int hold_at);
		logic [BYTE_W-1:0] feed[$];
		int                plen;
		int                cut;
		int                r;
		int                i;
		int                k;
		logic              eot;
		for (i = 0; i < items; i++) begin
			if (i == pause_at)
				drain();
			if (i == hold_at)
				hold_request = 1'b1;
			if (feed.size() == 0) begin
				plen = sb.match_len();
				r    = $urandom_range(0, 99);
				if (r < 40) begin
					for (k = 0; k < plen; k++)
						feed.push_back(sb.pat_word[BYTE_W*k +: BYTE_W]);
				end else if (r < 60) begin
					cut = $urandom_range(1, plen);
					for (k = 0; k < cut; k++)
						feed.push_back(sb.pat_word[BYTE_W*k +: BYTE_W]);
					feed.push_back(BYTE_W'($urandom_range(0, 255)));
				end else if (r < 80)
					feed.push_back(sb.pat_word[BYTE_W*$urandom_range(0, plen-1) +: BYTE_W]);
				else
					feed.push_back(BYTE_W'($urandom_range(0, 255)));
			end
			eot = ($urandom_range(0, 19) == 0) || (i == items-1 && $urandom_range(0, 1));
			send_byte(feed.pop_front(), eot);
		end
	endtask

	initial begin
		logic [WORD_W-1:0] pw;
		logic [WORD_W-1:0] rw;
		int                ph;
		int                k;
		sb = new();
		tx_idle_pct = 12;
		rx_idle_pct = 48;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: single zero byte pattern, empty replacement.
		// zero is deleted (quiet item), FF passes, a deleted last byte leaves a
		// bare end marker
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// "ab" -> eight bytes, replacement length above the maximum
		load_setting(ALL_REGS, 64'h6261, len_word(2), 64'hFFEE_DDCC_BBAA_9988, len_word(15));
		send_byte(CHAR_A, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(CHAR_A, 1'b0);
		send_byte(CHAR_A, 1'b1);

		// pattern length zero acts as one
		load_setting(ALL_REGS, 64'h41, len_word(0), 64'h5A, len_word(1));
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h41, 1'b1);

		// pattern length above the maximum acts as eight; all-ones pattern deleted
		load_setting(ALL_REGS, {8{8'hFF}}, len_word(9), '0, len_word(0));
		for (k = 0; k < 10; k++)
			send_byte(8'hFF, 1'b0);
		// pattern length write mid-text drops the two held bytes
		load_setting(4'b1 << REG_PATTERN_LEN, '0, len_word(8), '0, '0);
		send_byte(8'h00, 1'b0);
		// other registers keep the window
		load_setting(4'b1 << REG_REPLACEMENT_BYTES, '0, '0, 64'h1234, '0);
		send_byte(8'h01, 1'b1);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph / 3)
				0: begin
					tx_idle_pct = 12;
					rx_idle_pct = 48;
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct = 12;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (ph)
				0: load_setting(ALL_REGS, {$urandom, $urandom}, len_word(1),
					{$urandom, $urandom}, len_word(8));
				1: load_setting(ALL_REGS, {8{CHAR_A}}, len_word(8),
					{$urandom, $urandom}, len_word(0));
				2: load_setting(ALL_REGS, 64'h626161, len_word(3),
					{$urandom, $urandom}, len_word(2));
				3: load_setting(ALL_REGS, {8{8'hFF}}, len_word(8), '0, len_word(8));
				4: load_setting(ALL_REGS, '0, len_word(2), {8{8'hFF}}, len_word(1));
				default: begin
					// small alphabet so overlapping partial matches turn up
					for (k = 0; k < DEF_MAX_PAT_LEN; k++)
						pw[BYTE_W*k +: BYTE_W] = BYTE_W'(CHAR_A + $urandom_range(0, 2));
					rw = {$urandom, $urandom};
					load_setting(ALL_REGS, pw, len_word($urandom_range(0, 15)), rw,
						len_word($urandom_range(0, 15)));
				end
			endcase
			send_random_text(PHASE_ITEMS, (ph == 3) ? 20 : -1, (ph == 6) ? 10 : -1);
		end

		drain();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
